@@ rtl/core/rdf_pkg.sv @@
// shared types, codes and crc helpers for the register datagram framer
// no dependencies; imported by the channel interfaces and the top level
package rdf_pkg;

    localparam logic [7:0] SYNC_WRITE = 8'h05;
    localparam logic [7:0] SYNC_READ  = 8'h07;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_TOP    = 8'h80;
    localparam logic [7:0] BYTE_MASK  = 8'hFF;

    localparam int CRC_MSG_BITS = 48;
    localparam int FRAME_BYTES  = 8;

    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_RX    = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_READY    = 2'd1,
        ST_BAD_HEADER   = 2'd2,
        ST_CRC_MISMATCH = 2'd3
    } t_status;

    typedef logic [7:0] t_crc_cols [CRC_MSG_BITS];

    // column i is x^(i+8) mod p: the remainder that message bit i adds
    function automatic t_crc_cols crc_cols_build();
        t_crc_cols cols;
        logic [7:0] v;
        v = CRC_POLY;
        for (int i = 0; i < CRC_MSG_BITS; i++) begin
            cols[i] = v;
            v = ((v & CRC_TOP) != 8'h00) ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return cols;
    endfunction

    localparam t_crc_cols CRC_COLS = crc_cols_build();

    // msb-first crc-8, zero init, over up to six bytes; leading zero bytes are neutral
    function automatic logic [7:0] crc8_msg48(input logic [CRC_MSG_BITS-1:0] msg);
        logic [7:0] c;
        c = 8'h00;
        for (int i = 0; i < CRC_MSG_BITS; i++) begin
            if (msg[i]) begin
                c = c ^ CRC_COLS[i];
            end
        end
        return c & BYTE_MASK;
    endfunction

endpackage

@@ rtl/core/rdf_in_if.sv @@
// request channel of the register datagram framer
// depends on rdf_pkg
interface rdf_in_if
    import rdf_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [7:0]  reg_addr;
    logic [31:0] write_value;
    logic [7:0]  rx_byte;

    modport source (output valid, output req_type, output reg_addr, output write_value,
                    output rx_byte, input ready);
    modport sink (input valid, input req_type, input reg_addr, input write_value,
                  input rx_byte, output ready);
endinterface

@@ rtl/core/rdf_out_if.sv @@
// result channel of the register datagram framer
// depends on rdf_pkg
interface rdf_out_if
    import rdf_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        out_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] read_value;
    logic [1:0]  status;

    modport source (output valid, output out_kind, output tx_byte, output last,
                    output read_value, output status, input ready);
    modport sink (input valid, input out_kind, input tx_byte, input last,
                  input read_value, input status, output ready);
endinterface

@@ rtl/core/register_datagram_framer_crc8_unit.sv @@
// top level of the register datagram framer / deframer with crc-8 (poly 0x07)
// depends on rdf_pkg, rdf_in_if, rdf_out_if
//
// usage:
//   in_ch carries requests: write, read, or one received link byte. a request
//   is taken on a clock edge with valid and ready high.
//   out_ch carries results: transmit bytes (out_kind 0) and completions or read
//   results (out_kind 1); last marks the final result of a request.
//   the apb port holds link_enabled at byte addresses 0 to 3; pready is always high.
// timing:
//   a request is held in the input register until the frame register is free; a
//   request that gives results then loads the frame register, which drives out_ch.
//   results leave one per cycle from the frame register while out_ch.ready is high,
//   and frame serialization sets the rate. with the link enabled a write request gives
//   8 results and a read request 3, a completion 1; received bytes completing nothing give none.
// reset (i_rst_n low, synchronous): link disabled, receiver disarmed, both
//   pipeline registers empty.
// stall: while out_ch.ready is low the frame register holds; one more request
//   waits in the input register, then in_ch.ready drops.
module register_datagram_framer_crc8_unit
    import rdf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdf_in_if.sink      in_ch,
    rdf_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic r_link_enabled;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {31'd0, r_link_enabled} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_enabled <= 1'b0;
        end else if (cfg_wr) begin
            r_link_enabled <= pwdata[0];
        end
    end

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_req_type;
    logic [7:0]  r_in_reg_addr;
    logic [31:0] r_in_write_value;
    logic [7:0]  r_in_rx_byte;

    // frame register
    logic        r_frm_valid;
    logic        r_frm_kind;
    logic [2:0]  r_frm_left;
    logic [7:0]  r_frm_bytes [FRAME_BYTES];
    logic [31:0] r_frm_value;
    logic [1:0]  r_frm_status;

    // receiver state
    logic        r_read_armed, n_read_armed;
    logic [7:0]  r_expected_reg, n_expected_reg;
    logic [2:0]  r_rx_count, n_rx_count;
    logic [7:0]  r_rx_crc, n_rx_crc;
    logic [31:0] r_rx_value, n_rx_value;
    logic        r_header_bad, n_header_bad;

    logic        out_fire;
    logic        s2_free;
    logic        s1_go;
    logic        in_fire;

    assign out_fire = r_frm_valid & out_ch.ready;
    assign s2_free  = !r_frm_valid || (out_fire && (r_frm_left == 3'd0));
    assign s1_go    = r_in_valid & s2_free;
    assign in_ch.ready = !r_in_valid || s2_free;
    assign in_fire  = in_ch.valid & in_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s1_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_req_type    <= in_ch.req_type;
            r_in_reg_addr    <= in_ch.reg_addr;
            r_in_write_value <= in_ch.write_value;
            r_in_rx_byte     <= in_ch.rx_byte;
        end
    end

    // request processing
    logic        ld_frame;
    logic        ld_kind;
    logic [2:0]  ld_left;
    logic [7:0]  ld_bytes [FRAME_BYTES];
    logic [31:0] ld_value;
    logic [1:0]  ld_status;
    logic [7:0]  wr_crc;
    logic [7:0]  rd_crc;
    logic [7:0]  rx_crc_next;

    assign wr_crc = crc8_msg48({SYNC_WRITE, r_in_reg_addr, r_in_write_value});
    assign rd_crc = crc8_msg48({32'd0, SYNC_READ, r_in_reg_addr});
    assign rx_crc_next = crc8_msg48({40'd0, r_rx_crc ^ r_in_rx_byte});

    always_comb begin
        ld_frame  = 1'b0;
        ld_kind   = KIND_TX;
        ld_left   = 3'd0;
        ld_value  = 32'd0;
        ld_status = ST_OK;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            ld_bytes[i] = 8'h00;
        end
        n_read_armed   = r_read_armed;
        n_expected_reg = r_expected_reg;
        n_rx_count     = r_rx_count;
        n_rx_crc       = r_rx_crc;
        n_rx_value     = r_rx_value;
        n_header_bad   = r_header_bad;

        case (r_in_req_type)
            REQ_WRITE, REQ_READ: begin
                ld_frame = 1'b1;
                if (!r_link_enabled) begin
                    ld_kind   = KIND_DONE;
                    ld_status = ST_NOT_READY;
                end else if (r_in_req_type == REQ_WRITE) begin
                    ld_left     = 3'd7;
                    ld_bytes[0] = SYNC_WRITE;
                    ld_bytes[1] = r_in_reg_addr;
                    ld_bytes[2] = r_in_write_value[31:24];
                    ld_bytes[3] = r_in_write_value[23:16];
                    ld_bytes[4] = r_in_write_value[15:8];
                    ld_bytes[5] = r_in_write_value[7:0];
                    ld_bytes[6] = wr_crc;
                    ld_bytes[7] = wr_crc;
                end else begin
                    ld_left        = 3'd2;
                    ld_bytes[0]    = SYNC_READ;
                    ld_bytes[1]    = r_in_reg_addr;
                    ld_bytes[2]    = rd_crc;
                    n_read_armed   = 1'b1;
                    n_expected_reg = r_in_reg_addr;
                    n_rx_count     = 3'd0;
                    n_rx_crc       = 8'h00;
                    n_rx_value     = 32'd0;
                    n_header_bad   = 1'b0;
                end
            end
            REQ_RX: begin
                if (r_read_armed) begin
                    n_rx_count = r_rx_count + 3'd1;
                    case (r_rx_count)
                        3'd0: begin
                            if (r_in_rx_byte != SYNC_WRITE) begin
                                n_header_bad = 1'b1;
                            end
                            n_rx_crc = rx_crc_next;
                        end
                        3'd1: begin
                            if (r_in_rx_byte != r_expected_reg) begin
                                n_header_bad = 1'b1;
                            end
                            n_rx_crc = rx_crc_next;
                        end
                        3'd2, 3'd3, 3'd4, 3'd5: begin
                            n_rx_value = {r_rx_value[23:0], r_in_rx_byte};
                            n_rx_crc   = rx_crc_next;
                        end
                        3'd6: begin
                            // zero afterwards means the crc matched
                            n_rx_crc = r_rx_crc ^ r_in_rx_byte;
                        end
                        default: begin
                            ld_frame = 1'b1;
                            ld_kind  = KIND_DONE;
                            if (r_header_bad) begin
                                ld_status = ST_BAD_HEADER;
                            end else if (r_rx_crc != 8'h00) begin
                                ld_status = ST_CRC_MISMATCH;
                            end else begin
                                ld_value = r_rx_value;
                            end
                            n_read_armed = 1'b0;
                            n_rx_count   = 3'd0;
                            n_rx_crc     = 8'h00;
                            n_rx_value   = 32'd0;
                            n_header_bad = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_armed   <= 1'b0;
            r_expected_reg <= 8'h00;
            r_rx_count     <= 3'd0;
            r_rx_crc       <= 8'h00;
            r_rx_value     <= 32'd0;
            r_header_bad   <= 1'b0;
        end else if (s1_go) begin
            r_read_armed   <= n_read_armed;
            r_expected_reg <= n_expected_reg;
            r_rx_count     <= n_rx_count;
            r_rx_crc       <= n_rx_crc;
            r_rx_value     <= n_rx_value;
            r_header_bad   <= n_header_bad;
        end
    end

    // frame register: loads a whole frame, shifts one byte out per result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frm_valid <= 1'b0;
        end else if (s1_go && ld_frame) begin
            r_frm_valid <= 1'b1;
        end else if (out_fire && (r_frm_left == 3'd0)) begin
            r_frm_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && ld_frame) begin
            r_frm_kind   <= ld_kind;
            r_frm_left   <= ld_left;
            r_frm_value  <= ld_value;
            r_frm_status <= ld_status;
            for (int i = 0; i < FRAME_BYTES; i++) begin
                r_frm_bytes[i] <= ld_bytes[i];
            end
        end else if (out_fire && (r_frm_left != 3'd0)) begin
            r_frm_left <= r_frm_left - 3'd1;
            for (int i = 0; i < FRAME_BYTES - 1; i++) begin
                r_frm_bytes[i] <= r_frm_bytes[i + 1];
            end
        end
    end

    assign out_ch.valid      = r_frm_valid;
    assign out_ch.out_kind   = r_frm_kind;
    assign out_ch.tx_byte    = r_frm_bytes[0];
    assign out_ch.last       = (r_frm_left == 3'd0);
    assign out_ch.read_value = r_frm_value;
    assign out_ch.status     = r_frm_status;

`ifndef SYNTH
    a_done_is_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frm_valid && (r_frm_kind == KIND_DONE)) |-> (r_frm_left == 3'd0))
        else $error("completion result not marked last");

    a_count_needs_arm : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_count != 3'd0) |-> r_read_armed)
        else $error("receive count advanced without an armed read");

    a_frame_continues : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && (r_frm_left != 3'd0)) |=> r_frm_valid)
        else $error("frame dropped before its last byte");

    a_in_reg_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !s2_free) |=> (r_in_valid && $stable(r_in_req_type)
            && $stable(r_in_write_value)))
        else $error("pending request lost while frame register busy");
`endif

endmodule

@@ verif/rdf_datagram_check.sv @@
// result checker for the register datagram framer: tracks the link enable from the apb
// port, predicts the results of every accepted request and compares them in order
// depends on rdf_pkg, rdf_in_if and rdf_out_if
module rdf_datagram_check
    import rdf_pkg::*;
#(
    parameter logic [2:0] LINK_EN_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rdf_in_if           in_mon,
    rdf_out_if          out_mon,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [31:0] read_value;
        t_status     status;
    } t_result;

    t_result     results_due[$];
    int          fail_count = 0;

    logic        link_en;
    logic        armed;
    logic [7:0]  want_reg;
    logic [2:0]  rx_idx;
    logic [7:0]  rx_crc;
    logic [31:0] rx_word;
    logic        hdr_bad;

    assign o_fail_count = fail_count;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void queue_tx(input logic [7:0] b, input logic lst);
        results_due.push_back(t_result'{KIND_TX, b, lst, 32'd0, ST_OK});
    endfunction

    function automatic void queue_done(input logic [31:0] v, input t_status st);
        results_due.push_back(t_result'{KIND_DONE, 8'd0, 1'b1, v, st});
    endfunction

    function automatic void rx_clear();
        rx_idx  = 3'd0;
        rx_crc  = 8'd0;
        rx_word = 32'd0;
        hdr_bad = 1'b0;
    endfunction

    task automatic take_request(input logic [1:0] kind, input logic [7:0] ra,
                                input logic [31:0] wv, input logic [7:0] b);
        logic [7:0] frame [8];
        logic [7:0] crc;
        if (kind == REQ_WRITE || kind == REQ_READ) begin
            if (!link_en) begin
                queue_done(32'd0, ST_NOT_READY);
            end else if (kind == REQ_WRITE) begin
                frame[0] = SYNC_WRITE;
                frame[1] = ra;
                {frame[2], frame[3], frame[4], frame[5]} = wv;
                crc = 8'd0;
                for (int i = 0; i < 6; i++) begin
                    crc = crc8_step(crc, frame[i]);
                end
                frame[6] = crc;
                frame[7] = crc;
                for (int i = 0; i < 8; i++) begin
                    queue_tx(frame[i], i == 7);
                end
            end else begin
                queue_tx(SYNC_READ, 1'b0);
                queue_tx(ra, 1'b0);
                queue_tx(crc8_step(crc8_step(8'd0, SYNC_READ), ra), 1'b1);
                armed    = 1'b1;
                want_reg = ra;
                rx_clear();
            end
        end else if (kind == REQ_RX && armed) begin
            case (rx_idx)
                3'd0: begin
                    if (b != SYNC_WRITE) hdr_bad = 1'b1;
                    rx_crc = crc8_step(rx_crc, b);
                end
                3'd1: begin
                    if (b != want_reg) hdr_bad = 1'b1;
                    rx_crc = crc8_step(rx_crc, b);
                end
                3'd6: begin
                    rx_crc = rx_crc ^ b;
                end
                3'd7: begin
                    if (hdr_bad) begin
                        queue_done(32'd0, ST_BAD_HEADER);
                    end else if (rx_crc != 8'd0) begin
                        queue_done(32'd0, ST_CRC_MISMATCH);
                    end else begin
                        queue_done(rx_word, ST_OK);
                    end
                    armed = 1'b0;
                end
                default: begin
                    rx_word = {rx_word[23:0], b};
                    rx_crc  = crc8_step(rx_crc, b);
                end
            endcase
            if (rx_idx == 3'd7) begin
                rx_clear();
            end else begin
                rx_idx = rx_idx + 3'd1;
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_result();
        t_result want;
        if (results_due.size() == 0) begin
            $error("result with nothing pending: out_kind %0d tx_byte 0x%0h status %0d",
                   out_mon.out_kind, out_mon.tx_byte, out_mon.status);
            fail_count++;
        end else begin
            want = results_due.pop_front();
            check_field("out_kind", 32'(want.kind), 32'(out_mon.out_kind));
            check_field("tx_byte", 32'(want.tx_byte), 32'(out_mon.tx_byte));
            check_field("last", 32'(want.last), 32'(out_mon.last));
            check_field("read_value", want.read_value, out_mon.read_value);
            check_field("status", 32'(want.status), 32'(out_mon.status));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            link_en  = 1'b0;
            armed    = 1'b0;
            want_reg = 8'd0;
            rx_clear();
            results_due.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == LINK_EN_ADDR) begin
                link_en = pwdata[0];
            end
            if (in_mon.valid && in_mon.ready) begin
                take_request(in_mon.req_type, in_mon.reg_addr, in_mon.write_value,
                             in_mon.rx_byte);
            end
            if (out_mon.valid && out_mon.ready) begin
                check_result();
            end
        end
        o_pending = results_due.size();
    end

endmodule

@@ verif/tb.sv @@
// testbench top for the register datagram framer: clock, reset, apb writes, request
// stimulus with random gaps and result back-pressure; the checker gives the verdict input
// depends on rdf_pkg, rdf_in_if, rdf_out_if, rdf_datagram_check and the framer top level
module tb;
    import rdf_pkg::*;

    localparam logic [2:0] ADDR_LINK_EN  = 3'd0;
    localparam logic [1:0] REQ_RESERVED  = 2'd3;
    localparam int         RANDOM_ITEMS  = 400;
    localparam int         PHASE_ITEMS   = 50;
    localparam int         SQUEEZE_LEN   = 400;
    localparam int         CYCLE_LIMIT   = 600000;

    typedef enum logic [2:0] {
        FAULT_NONE,
        FAULT_SYNC,
        FAULT_REG,
        FAULT_CRC,
        FAULT_SYNC_CRC
    } t_reply_fault;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          squeeze_asked = 0;
    int          cycles = 0;
    int          useful_items = 0;
    bit          sender_steady = 1'b0;

    rdf_in_if  in_ch();
    rdf_out_if out_ch();

    register_datagram_framer_crc8_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rdf_datagram_check #(.LINK_EN_ADDR(ADDR_LINK_EN)) u_datagram_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int unsigned gap_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [31:0] any_word();
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) return 32'h0000_0000;
        if (roll == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input logic [1:0] kind, input logic [7:0] ra,
                            input logic [31:0] wv, input logic [7:0] rb);
        int unsigned gap;
        gap = sender_steady ? 0 : gap_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= kind;
        in_ch.reg_addr    <= ra;
        in_ch.write_value <= wv;
        in_ch.rx_byte     <= rb;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic link_write(input logic en);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LINK_EN;
        pwdata  <= {31'($urandom), en};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_reply(input logic [7:0] ra, input logic [31:0] val,
                              input t_reply_fault fault, input int nbytes);
        logic [7:0] frame [8];
        frame[0] = SYNC_WRITE;
        frame[1] = ra;
        if (fault == FAULT_SYNC || fault == FAULT_SYNC_CRC) begin
            frame[0] = SYNC_WRITE ^ 8'($urandom_range(255, 1));
        end
        if (fault == FAULT_REG) begin
            frame[1] = ra ^ 8'($urandom_range(255, 1));
        end
        {frame[2], frame[3], frame[4], frame[5]} = val;
        frame[6] = crc8_msg48({frame[0], frame[1], val});
        if (fault == FAULT_CRC || fault == FAULT_SYNC_CRC) begin
            frame[6] = frame[6] ^ 8'($urandom_range(255, 1));
        end
        frame[7] = 8'($urandom);
        for (int i = 0; i < nbytes; i++) begin
            send_req(REQ_RX, 8'($urandom), $urandom, frame[i]);
        end
    endtask

    task automatic random_request();
        int unsigned  roll;
        int unsigned  nbytes;
        logic [7:0]   ra;
        t_reply_fault fault;
        roll = $urandom_range(99);
        ra = 8'($urandom);
        if (roll < 65) begin
            nbytes = (roll < 55) ? 8 : $urandom_range(7, 1);
            case ($urandom_range(9))
                0: fault = FAULT_SYNC;
                1: fault = FAULT_REG;
                2: fault = FAULT_CRC;
                3: fault = FAULT_SYNC_CRC;
                default: fault = FAULT_NONE;
            endcase
            send_req(REQ_READ, ra, any_word(), 8'($urandom));
            send_reply(ra, any_word(), fault, nbytes);
            useful_items += 1 + nbytes;
        end else if (roll < 85) begin
            send_req(REQ_WRITE, ra, any_word(), 8'($urandom));
            useful_items++;
        end else if (roll < 95) begin
            repeat ($urandom_range(3, 1)) begin
                send_req(REQ_RX, ra, $urandom, ($urandom_range(1) == 0) ? SYNC_WRITE
                                                                        : 8'($urandom));
            end
        end else begin
            send_req(REQ_RESERVED, ra, $urandom, 8'($urandom));
        end
    endtask

    initial begin : receiver
        int unsigned hold;
        int unsigned mode_left;
        int          squeeze_done;
        bit          calm;
        hold = 0;
        mode_left = 0;
        squeeze_done = 0;
        calm = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                calm = ($urandom_range(3) == 0);
                mode_left = $urandom_range(300, 50);
            end
            mode_left--;
            if (squeeze_done < squeeze_asked) begin
                hold = SQUEEZE_LEN;
                squeeze_done++;
            end else if (hold == 0 && !calm) begin
                hold = gap_len();
            end
            if (hold > 0) begin
                out_ch.ready <= 1'b0;
                hold--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int phase;
        int phase_start;
        in_ch.valid       = 1'b0;
        in_ch.req_type    = REQ_WRITE;
        in_ch.reg_addr    = 8'd0;
        in_ch.write_value = 32'd0;
        in_ch.rx_byte     = 8'd0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = ADDR_LINK_EN;
        pwdata  = 32'd0;
        i_rst_n = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // link still down after reset: requests refused, stray bytes and reserved type dropped
        send_req(REQ_WRITE, 8'h00, 32'h0000_0000, 8'h00);
        send_req(REQ_READ, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        send_req(REQ_RX, 8'h00, 32'h0000_0000, SYNC_WRITE);
        send_req(REQ_RESERVED, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        settle();

        link_write(1'b1);
        send_req(REQ_WRITE, 8'h00, 32'h0000_0000, 8'h00);
        send_req(REQ_WRITE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
        // partial response, then a read that restarts the receiver
        send_req(REQ_READ, 8'h3C, 32'h0, 8'h0);
        send_reply(8'h3C, 32'h1234_5678, FAULT_NONE, 3);
        send_req(REQ_READ, 8'hFF, 32'h0, 8'h0);
        settle();
        // armed receiver keeps taking bytes with the link down; header error wins over crc
        link_write(1'b0);
        send_reply(8'hFF, 32'h0000_0000, FAULT_SYNC_CRC, 8);
        settle();

        phase = 0;
        while (useful_items < RANDOM_ITEMS) begin
            settle();
            link_write((phase == 0) ? 1'b1 : ($urandom_range(4) != 0));
            sender_steady = ($urandom_range(3) == 0);
            if (phase == 1 || phase == 5) begin
                sender_steady = 1'b1;
                squeeze_asked++;
            end
            phase_start = useful_items;
            while (useful_items - phase_start < PHASE_ITEMS) begin
                random_request();
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/rdf_pkg.sv
rtl/core/rdf_in_if.sv
rtl/core/rdf_out_if.sv
rtl/core/register_datagram_framer_crc8_unit.sv
verif/rdf_datagram_check.sv
verif/tb.sv
